// ----- sv/mkps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkps_pkg
// Types, constants and helpers shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
package mkps_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 16;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd40;

   // Per-row last-key code: 0..15 is a key, 16 means no key
   localparam int          KEY_CODE_W  = 5;
   localparam logic [4:0]  NO_KEY_CODE = 5'd16;

   localparam int NUM_ROWS = 4;

   // Register indexes on the CSR port (byte address = 4 * index)
   localparam logic REG_DEBOUNCE_TICKS = 1'b0;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // Column number for exactly one low line, otherwise NO_KEY_CODE
   function automatic logic [4:0] decode_columns(input logic [3:0] lines);
      logic [4:0] col;
      unique case (lines)
         4'b1110: col = 5'd0;
         4'b1101: col = 5'd1;
         4'b1011: col = 5'd2;
         4'b0111: col = 5'd3;
         default: col = NO_KEY_CODE;
      endcase
      return col;
   endfunction

endpackage
`default_nettype wire

// ----- sv/mkps_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkps_fifo
// Key FIFO: circular buffer with one slot kept free, registered read data.
// ----------------------------------------------------------------------------
module mkps_fifo #(
   parameter int FIFO_DEPTH = mkps_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push_en,
   input  wire [3:0]                 push_key,
   input  wire                       pop_en,
   output logic [3:0]                pop_key,
   output mkps_pkg::fifo_status_type status
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

   logic [3:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_next;
   logic [3:0]       rd_data_ff;

   assign wr_ptr_next = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_next = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);

   assign status.empty = (rd_ptr_ff == wr_ptr_ff);
   assign status.full  = (wr_ptr_next == rd_ptr_ff);

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_next : wr_ptr_ff;
      rd_ptr_in = pop_en  ? rd_ptr_next : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wr_ptr_ff] <= push_key;
      end
   end

   // read data only moves on a pop, so it holds while the response stalls
   always_ff @(posedge clock) begin
      if (pop_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_key = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/matrix_keypad_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 key matrix scanner with debounce hold-off and a key FIFO.
// ----------------------------------------------------------------------------
// Each request is a tick (tuser = 0, tdata[3:0] = active-low column lines of
// the newly selected row) or a pop (tuser = 1). Every request gives exactly
// one response, in the cycle after it is accepted; a request can be taken every
// cycle, and while the response register is full a new request is taken in
// the same cycle the waiting response leaves. A tick with a non-zero
// hold-off count only counts down; otherwise the row advances and a change of
// that row's key reloads the hold-off and, for a real key, pushes it into
// the FIFO (or drops it and flags key_dropped when the FIFO is full). The
// FIFO holds FIFO_DEPTH-1 keys. debounce_ticks sits at CSR byte address 0.
module matrix_keypad_scanner #(
   parameter int FIFO_DEPTH = mkps_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [3:0] column_lines, [7:4] zero
   input  wire         req_tuser,   // [0] mode
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] row_select, [5:2] pop_key,
                                    // [6] key_dropped, [7] zero
   output logic        rsp_tuser,   // [0] pop_valid
   // CSR port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] debounce_ff;
   logic       csr_wr;

   logic [1:0]                        row_ff, row_in, row_next;
   logic [mkps_pkg::KEY_CODE_W-1:0]   last_key_ff [mkps_pkg::NUM_ROWS];
   logic [7:0]                        holdoff_ff, holdoff_in;

   logic                      accept;
   mkps_pkg::mode_type        mode;
   logic                      is_tick, scan, changed, push_req, push_en, pop_en;
   logic [4:0]                col;
   logic [4:0]                key;
   mkps_pkg::fifo_status_type fifo_status;
   logic [3:0]                fifo_key;

   logic       rsp_valid_ff;
   logic [1:0] row_select_ff;
   logic       pop_valid_ff, pop_valid_in;
   logic       dropped_ff, dropped_in;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready
                   & (csr_paddr[2] == mkps_pkg::REG_DEBOUNCE_TICKS);
   assign csr_prdata = (csr_paddr[2] == mkps_pkg::REG_DEBOUNCE_TICKS)
                       ? {24'd0, debounce_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mkps_pkg::DEBOUNCE_RESET;
      end else if (csr_wr) begin
         debounce_ff <= csr_pwdata[7:0];
      end
   end

   // ---------------- scan logic ----------------
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign mode       = mkps_pkg::mode_type'(req_tuser);

   assign is_tick  = accept & (mode == mkps_pkg::MODE_TICK);
   assign pop_en   = accept & (mode == mkps_pkg::MODE_POP) & ~fifo_status.empty;
   assign scan     = is_tick & (holdoff_ff == 8'd0);
   assign row_next = row_ff + 2'd1;
   assign col      = mkps_pkg::decode_columns(req_tdata[3:0]);
   // key = column + 4*row
   assign key      = (col == mkps_pkg::NO_KEY_CODE) ? mkps_pkg::NO_KEY_CODE
                                                    : {1'b0, row_next, col[1:0]};
   assign changed  = scan & (key != last_key_ff[row_next]);
   assign push_req = changed & (key != mkps_pkg::NO_KEY_CODE);
   assign push_en  = push_req & ~fifo_status.full;

   always_comb begin
      row_in       = scan ? row_next : row_ff;
      holdoff_in   = holdoff_ff;
      if (is_tick && holdoff_ff != 8'd0) begin
         holdoff_in = holdoff_ff - 8'd1;
      end else if (changed) begin
         holdoff_in = debounce_ff;
      end
      pop_valid_in = pop_en;
      dropped_in   = push_req & fifo_status.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         holdoff_ff <= '0;
         for (int i = 0; i < mkps_pkg::NUM_ROWS; i++) begin
            last_key_ff[i] <= mkps_pkg::NO_KEY_CODE;
         end
      end else begin
         row_ff     <= row_in;
         holdoff_ff <= holdoff_in;
         if (changed) begin
            last_key_ff[row_next] <= key;
         end
      end
   end

   mkps_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_en  (push_en),
      .push_key (key[3:0]),
      .pop_en   (pop_en),
      .pop_key  (fifo_key),
      .status   (fifo_status)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_select_ff <= row_in;
         pop_valid_ff  <= pop_valid_in;
         dropped_ff    <= dropped_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = pop_valid_ff;
   assign rsp_tdata  = {1'b0, dropped_ff, (pop_valid_ff ? fifo_key : 4'd0), row_select_ff};

endmodule
`default_nettype wire
